// ===== design/imu_sfp_pkg.sv =====
// Package: frame constants, byte positions and the result record of the IMU frame parser.
`default_nettype none

package imu_sfp_pkg;

    // Frame bytes
    localparam logic [7:0] HDR_BYTE = 8'h55;
    localparam logic [7:0] TYPE_ACC = 8'h51;
    localparam logic [7:0] TYPE_GYR = 8'h52;
    localparam logic [7:0] TYPE_ANG = 8'h53;

    // Frame type codes as reported
    localparam logic [1:0] FT_ACC = 2'd0;
    localparam logic [1:0] FT_GYR = 2'd1;
    localparam logic [1:0] FT_ANG = 2'd2;

    // Byte positions within a frame
    localparam logic [3:0] POS_HEADER = 4'd0;
    localparam logic [3:0] POS_TYPE   = 4'd1;
    localparam logic [3:0] POS_LAST   = 4'd10;

    // Payload store depth (data bytes 2..9)
    localparam int PAYLOAD_BYTES = 8;

    // Temperature scale: round(65536*256/340), offset 36.25*256
    localparam logic signed [16:0] TEMP_MUL = 17'sd49345;
    localparam logic signed [16:0] TEMP_OFS = 17'sd9280;

    // One decoded frame
    typedef struct packed {
        logic [1:0]         frame_type;
        logic signed [15:0] axis_x;
        logic signed [15:0] axis_y;
        logic signed [15:0] axis_z;
        logic signed [16:0] temperature_q8;
        logic               checksum_ok;
    } frame_result_t;

endpackage

`default_nettype wire

// ===== design/imu_sfp_frame_calc.sv =====
// Frame result logic: axis words, temperature scaling and sum check for the last byte.
`default_nettype none

module imu_sfp_frame_calc
    import imu_sfp_pkg::*;
(
    input  wire logic [8*PAYLOAD_BYTES-1:0] payload,     // data byte k at [8k+7:8k]
    input  wire logic [1:0]                 type_code,
    input  wire logic [7:0]                 running_sum,
    input  wire logic [7:0]                 sum_byte,
    input  wire logic                       check_enable,
    output frame_result_t                   result
);

    logic signed [15:0] temp_raw;
    logic signed [32:0] temp_prod;
    logic signed [32:0] temp_shift;
    logic signed [16:0] temp_scaled;

    // Temperature: floor(raw * mul / 65536) + offset, shift is the floor
    assign temp_raw    = payload[63:48];
    assign temp_prod   = 33'(temp_raw) * 33'(TEMP_MUL);
    assign temp_shift  = temp_prod >>> 16;
    assign temp_scaled = temp_shift[16:0] + TEMP_OFS;

    // Assemble result
    always_comb
    begin
        result.frame_type     = type_code;
        result.axis_x         = payload[15:0];
        result.axis_y         = payload[31:16];
        result.axis_z         = payload[47:32];
        result.temperature_q8 = (type_code == FT_ACC) ? temp_scaled : 17'sd0;
        result.checksum_ok    = !check_enable || (running_sum == sum_byte);
    end

endmodule

`default_nettype wire

// ===== design/imu_serial_frame_parser_unit.sv =====
// Top level: 11-byte IMU frame deframer on a byte stream with one result per complete frame.
// A frame's result is registered and valid in the cycle after its sum byte is transferred.
// Throughput: one byte per cycle; the sum byte stalls only while the output register
// still holds an untaken result, other bytes are always taken.
// Reset (rst_n, async active low): header search, sum and type cleared, check disabled,
// output empty. Payload bytes are not reset; each frame writes them before use.
`default_nettype none

module imu_serial_frame_parser_unit
    import imu_sfp_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    // Configuration: check_enable
    input  wire logic        cfg_wr_en,
    input  wire logic        cfg_wr_data,
    // Byte stream in
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,      // [7:0] rx_byte
    // Frame results out
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [71:0]      m_tdata,      // [15:0] axis_x, [31:16] axis_y, [47:32] axis_z,
                                           // [64:48] temperature_q8, [71:65] zero
    output logic [2:0]       m_tuser       // [1:0] frame_type, [2] checksum_ok
);

    logic                         check_en_reg;
    logic [3:0]                   pos_reg;
    logic [3:0]                   pos_next;
    logic [1:0]                   type_reg;
    logic [1:0]                   type_next;
    logic [7:0]                   sum_reg;
    logic [7:0]                   sum_next;
    logic [8*PAYLOAD_BYTES-1:0]   payload_reg;
    logic                         out_valid_reg;
    frame_result_t                out_reg;
    frame_result_t                calc_result;
    logic                         in_xfer;
    logic                         emit;
    logic [2:0]                   slot;

    // Only the sum byte needs room in the output register
    assign s_tready = !((pos_reg == POS_LAST) && out_valid_reg && !m_tready);
    assign in_xfer  = s_tvalid && s_tready;
    assign emit     = in_xfer && (pos_reg == POS_LAST);
    assign slot     = 3'(pos_reg - 4'd2);

    // Configuration register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            check_en_reg <= 1'b0;
        else if (cfg_wr_en)
            check_en_reg <= cfg_wr_data;
    end

    // Parser next state
    always_comb
    begin
        pos_next  = pos_reg;
        type_next = type_reg;
        sum_next  = sum_reg;
        unique case (pos_reg)
            POS_HEADER:
            begin
                if (s_tdata == HDR_BYTE)
                begin
                    sum_next = s_tdata;
                    pos_next = POS_TYPE;
                end
            end
            POS_TYPE:
            begin
                if (s_tdata == TYPE_ACC || s_tdata == TYPE_GYR || s_tdata == TYPE_ANG)
                begin
                    type_next = 2'(s_tdata - TYPE_ACC);
                    sum_next  = sum_reg + s_tdata;
                    pos_next  = 4'd2;
                end
                else
                begin
                    pos_next = POS_HEADER;
                end
            end
            4'd2, 4'd3, 4'd4, 4'd5, 4'd6, 4'd7, 4'd8, 4'd9:
            begin
                sum_next = sum_reg + s_tdata;
                pos_next = pos_reg + 4'd1;
            end
            default:
            begin
                // Sum byte, or a position that cannot arise: back to header search
                pos_next = POS_HEADER;
            end
        endcase
    end

    // Parser state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg  <= POS_HEADER;
            type_reg <= FT_ACC;
            sum_reg  <= 8'd0;
        end
        else if (in_xfer)
        begin
            pos_reg  <= pos_next;
            type_reg <= type_next;
            sum_reg  <= sum_next;
        end
    end

    // Payload store, data bytes land by position
    always_ff @(posedge clk)
    begin
        if (in_xfer && (pos_reg >= 4'd2) && (pos_reg < POS_LAST))
            payload_reg[8*slot +: 8] <= s_tdata;
    end

    imu_sfp_frame_calc u_calc
    (
        .payload      (payload_reg),
        .type_code    (type_reg),
        .running_sum  (sum_reg),
        .sum_byte     (s_tdata),
        .check_enable (check_en_reg),
        .result       (calc_result)
    );

    // Output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (emit)
            out_valid_reg <= 1'b1;
        else if (m_tready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (emit)
            out_reg <= calc_result;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {7'd0, out_reg.temperature_q8, out_reg.axis_z,
                       out_reg.axis_y, out_reg.axis_x};
    assign m_tuser  = {out_reg.checksum_ok, out_reg.frame_type};

endmodule

`default_nettype wire

// ===== tb/imu_serial_frame_parser_unit_tb.sv =====
// Testbench: drives byte streams into the IMU frame parser and checks every decoded frame.
`default_nettype none

module imu_serial_frame_parser_unit_tb;
    import imu_sfp_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    // Decodes the byte stream alongside the block and holds the frames still owed
    class frame_scoreboard;
        bit                 check_en;
        logic [3:0]         pos;
        logic [1:0]         kind;
        logic [7:0]         payload [PAYLOAD_BYTES];
        logic [7:0]         sum;
        frame_result_t      frames_due [$];
        int                 errors;

        function new();
            check_en = 1'b0;
            pos      = POS_HEADER;
            kind     = FT_ACC;
            sum      = 8'd0;
            errors   = 0;
            foreach (payload[i])
                payload[i] = 8'd0;
        endfunction

        function bit at_header();
            return pos == POS_HEADER;
        endfunction

        function int pending();
            return frames_due.size();
        endfunction

        // One accepted byte; a sum byte queues the frame it completes
        function void note_byte(logic [7:0] b);
            frame_result_t      fr;
            logic signed [15:0] raw_t;
            longint             prod;
            longint             temp;
            if (pos == POS_HEADER) begin
                if (b == HDR_BYTE) begin
                    sum = b;
                    pos = POS_TYPE;
                end
            end
            else if (pos == POS_TYPE) begin
                if (b == TYPE_ACC || b == TYPE_GYR || b == TYPE_ANG) begin
                    kind = 2'(b - TYPE_ACC);
                    sum  = sum + b;
                    pos  = pos + 4'd1;
                end
                else
                    pos = POS_HEADER;
            end
            else if (pos < POS_LAST) begin
                payload[pos - 4'd2] = b;
                sum = sum + b;
                pos = pos + 4'd1;
            end
            else if (pos > POS_LAST)
                pos = POS_HEADER;
            else begin
                pos           = POS_HEADER;
                fr.frame_type = kind;
                fr.axis_x     = {payload[1], payload[0]};
                fr.axis_y     = {payload[3], payload[2]};
                fr.axis_z     = {payload[5], payload[4]};
                // floor(raw * scale / 2^16) + offset, acceleration frames only
                raw_t = {payload[7], payload[6]};
                prod  = longint'(raw_t) * longint'(TEMP_MUL);
                temp  = (prod >>> 16) + longint'(TEMP_OFS);
                fr.temperature_q8 = (kind == FT_ACC) ? 17'(temp) : 17'd0;
                fr.checksum_ok    = !check_en || (sum == b);
                frames_due.push_back(fr);
            end
        endfunction

        function void compare(string name, logic [16:0] exp_v, logic [16:0] act_v);
            if (exp_v !== act_v) begin
                $error("%s: expected 0x%0h, actual 0x%0h", name, exp_v, act_v);
                errors++;
            end
        endfunction

        // One accepted result against the oldest frame owed
        function void check_frame(logic [71:0] td, logic [2:0] tu);
            frame_result_t fr;
            if (frames_due.size() == 0) begin
                $error("frame result with no frame owed: tdata 0x%0h tuser 0x%0h", td, tu);
                errors++;
                return;
            end
            fr = frames_due.pop_front();
            compare("frame_type", 17'(fr.frame_type), 17'(tu[1:0]));
            compare("checksum_ok", 17'(fr.checksum_ok), 17'(tu[2]));
            // Axis words compared as raw 16-bit patterns
            compare("axis_x", {1'b0, fr.axis_x}, 17'(td[15:0]));
            compare("axis_y", {1'b0, fr.axis_y}, 17'(td[31:16]));
            compare("axis_z", {1'b0, fr.axis_z}, 17'(td[47:32]));
            compare("temperature_q8", fr.temperature_q8, td[64:48]);
            compare("tdata_pad", 17'd0, 17'(td[71:65]));
        endfunction
    endclass

    logic        clk;
    logic        rst_n;
    logic        cfg_wr_en;
    logic        cfg_wr_data;
    logic        s_tvalid;
    logic        s_tready;
    logic [7:0]  s_tdata;
    logic        m_tvalid;
    logic        m_tready;
    logic [71:0] m_tdata;
    logic [2:0]  m_tuser;

    frame_scoreboard sb;
    int              bytes_sent;
    int              send_run;

    imu_serial_frame_parser_unit u_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser)
    );

    // Clock
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Idle cycles before one transfer; now and then a stretch with none
    function automatic int draw_gap(inout int run);
        if (run > 0) begin
            run--;
            return 0;
        end
        if ($urandom_range(0, 15) == 0) begin
            run = $urandom_range(10, 30);
            return 0;
        end
        return $urandom_range(0, 8);
    endfunction

    // Axis words lean toward the extremes
    function automatic logic [15:0] rand_word();
        case ($urandom_range(0, 7))
            0:       return 16'h8000;
            1:       return 16'h7FFF;
            2:       return 16'h0000;
            3:       return 16'hFFFF;
            default: return 16'($urandom_range(0, 65535));
        endcase
    endfunction

    // One byte transfer after a random gap
    task automatic send_byte(logic [7:0] b);
        int gap;
        gap = draw_gap(send_run);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        do
            @(posedge clk);
        while (!s_tready);
        sb.note_byte(b);
        bytes_sent++;
    endtask

    // First nbytes of a frame; the sum byte is spoiled unless good_sum
    task automatic send_frame(logic [7:0] type_byte, logic [15:0] x, logic [15:0] y,
                              logic [15:0] z, logic [15:0] t, bit good_sum, int nbytes);
        logic [7:0] f [11];
        logic [7:0] s;
        f[0] = HDR_BYTE;
        f[1] = type_byte;
        f[2] = x[7:0];
        f[3] = x[15:8];
        f[4] = y[7:0];
        f[5] = y[15:8];
        f[6] = z[7:0];
        f[7] = z[15:8];
        f[8] = t[7:0];
        f[9] = t[15:8];
        s = 8'd0;
        for (int i = 0; i < 10; i++)
            s = s + f[i];
        f[10] = good_sum ? s : s ^ 8'($urandom_range(1, 255));
        for (int i = 0; i < nbytes; i++)
            send_byte(f[i]);
    endtask

    // Mostly whole frames, some with spoiled sums; the rest bad types, noise and cut-off frames
    task automatic send_random_unit();
        int         mode;
        logic [7:0] tb_byte;
        mode    = $urandom_range(0, 99);
        tb_byte = TYPE_ACC + 8'($urandom_range(0, 2));
        if (mode >= 70 && mode < 80) begin
            if ($urandom_range(0, 3) == 0)
                tb_byte = HDR_BYTE;
            else begin
                do
                    tb_byte = 8'($urandom_range(0, 255));
                while (tb_byte >= TYPE_ACC && tb_byte <= TYPE_ANG);
            end
        end
        if (mode >= 80 && mode < 90) begin
            repeat ($urandom_range(1, 3))
                send_byte(8'($urandom_range(0, 255)));
        end
        else
            send_frame(tb_byte, rand_word(), rand_word(), rand_word(), rand_word(),
                       $urandom_range(0, 9) < 7, (mode >= 90) ? $urandom_range(2, 10) : 11);
    endtask

    // Back to header search, then drain all owed frames
    task automatic settle();
        while (!sb.at_header())
            send_byte(8'h00);
        s_tvalid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_check(bit v);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= v;
        @(posedge clk);
        cfg_wr_en   <= 1'b0;
        sb.check_en = v;
    endtask

    // Result side; one long hold-off lets the parser fill and stall its input
    initial
    begin
        int gap;
        int run;
        int taken;
        run   = 0;
        taken = 0;
        do
            @(posedge clk);
        while (!rst_n);
        forever begin
            gap = (taken == 15) ? 300 : draw_gap(run);
            if (gap > 0) begin
                m_tready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            m_tready <= 1'b1;
            do
                @(posedge clk);
            while (!m_tvalid);
            sb.check_frame(m_tdata, m_tuser);
            taken++;
        end
    end

    // Stimulus
    initial
    begin
        int target;
        sb          = new();
        bytes_sent  = 0;
        send_run    = 0;
        rst_n       = 1'b0;
        cfg_wr_en   = 1'b0;
        cfg_wr_data = 1'b0;
        s_tvalid    = 1'b0;
        s_tdata     = 8'h00;
        m_tready    = 1'b0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Check off: extreme words, a stray byte, a header in the type slot
        write_check(1'b0);
        send_frame(TYPE_ACC, 16'h7FFF, 16'h8000, 16'h0000, 16'h7FFF, 1'b1, 11);
        send_byte(8'h00);
        send_byte(HDR_BYTE);
        send_byte(HDR_BYTE);
        settle();

        // Check on: lowest temperature with a spoiled sum
        write_check(1'b1);
        send_frame(TYPE_ACC, 16'hFFFF, 16'h0001, 16'h7FFF, 16'h8000, 1'b0, 11);
        settle();

        // Random phases, check enable alternating
        for (int ph = 0; ph < 4; ph++) begin
            write_check(ph % 2 == 0);
            target = bytes_sent + 175;
            while (bytes_sent < target)
                send_random_unit();
            settle();
        end

        repeat (10) @(posedge clk);
        if (sb.errors == 0)
            $display("imu_serial_frame_parser_unit_tb OK");
        else
            $display("imu_serial_frame_parser_unit_tb NOT OK");
        $finish;
    end

    // Watchdog
    initial
    begin
        #2000000;
        $display("imu_serial_frame_parser_unit_tb NOT OK");
        $finish;
    end

endmodule

`default_nettype wire
